// ===== sv/tmse_pkg.sv =====
package tmse_pkg;

    localparam int STATE_COUNT  = 64;
    localparam int SYMBOL_COUNT = 16;
    localparam int TAPE_DEPTH   = 1024;

    localparam int STATE_W    = $clog2(STATE_COUNT);
    localparam int SYM_W      = $clog2(SYMBOL_COUNT);
    localparam int POS_W      = $clog2(TAPE_DEPTH);
    localparam int RULE_AW    = STATE_W + SYM_W;
    localparam int RULE_DEPTH = STATE_COUNT * SYMBOL_COUNT;
    localparam int KIND_W     = 3;

    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] REG_ACCEPT = 2'd0;

    localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RESTART = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STEP    = 3'd4;

    localparam logic [STATE_W-1:0] ACCEPT_RESET = STATE_W'(63);
    localparam logic [POS_W-1:0]   TAPE_LAST    = POS_W'(TAPE_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_STEPPED  = 3'd1,
        ST_ACCEPTED = 3'd2,
        ST_NO_RULE  = 3'd3,
        ST_OFF_TAPE = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_WRITE,
        OP_READ,
        OP_RESTART,
        OP_STEP,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_TAPE,
        BS_RULE
    } t_bstate;

    typedef struct packed {
        logic               defined;
        logic               move_right;
        logic [SYM_W-1:0]   write_sym;
        logic [STATE_W-1:0] next_state;
    } t_rule;

    localparam int RULE_W = $bits(t_rule);

    typedef struct packed {
        t_op                op;
        logic [RULE_AW-1:0] rule_addr;
        t_rule              rule;
        logic [POS_W-1:0]   pos;
        logic [SYM_W-1:0]   sym;
    } t_req;

endpackage

// ===== sv/tmse_ram.sv =====
module tmse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tmse_front.sv =====
module tmse_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tmse_pkg::KIND_W-1:0]    i_kind,
    input  logic [tmse_pkg::STATE_W-1:0]   i_rule_state,
    input  logic [tmse_pkg::SYM_W-1:0]     i_rule_symbol,
    input  logic [tmse_pkg::STATE_W-1:0]   i_rule_next_state,
    input  logic [tmse_pkg::SYM_W-1:0]     i_rule_write_symbol,
    input  logic                           i_rule_move_right,
    input  logic                           i_rule_defined,
    input  logic [tmse_pkg::POS_W-1:0]     i_cell_position,
    input  logic [tmse_pkg::SYM_W-1:0]     i_cell_symbol,
    output logic                           o_busy,
    output logic                           o_req_valid,
    output tmse_pkg::t_req                 o_req,
    input  logic                           i_req_pop
);

    tmse_pkg::t_req                r_q [tmse_pkg::Q_DEPTH];
    logic [tmse_pkg::Q_PW-1:0]     r_wr_ptr;
    logic [tmse_pkg::Q_PW-1:0]     r_rd_ptr;
    logic [tmse_pkg::Q_CW-1:0]     r_count;
    tmse_pkg::t_req                req_in;
    logic                          push;
    logic                          pop;

    always_comb begin
        case (i_kind)
            tmse_pkg::KIND_LOAD:    req_in.op = tmse_pkg::OP_LOAD;
            tmse_pkg::KIND_WRITE:   req_in.op = tmse_pkg::OP_WRITE;
            tmse_pkg::KIND_READ:    req_in.op = tmse_pkg::OP_READ;
            tmse_pkg::KIND_RESTART: req_in.op = tmse_pkg::OP_RESTART;
            tmse_pkg::KIND_STEP:    req_in.op = tmse_pkg::OP_STEP;
            default:                req_in.op = tmse_pkg::OP_NOP;
        endcase
        req_in.rule_addr       = {i_rule_state, i_rule_symbol};
        req_in.rule.defined    = i_rule_defined;
        req_in.rule.move_right = i_rule_move_right;
        req_in.rule.write_sym  = i_rule_write_symbol;
        req_in.rule.next_state = i_rule_next_state;
        req_in.pos             = i_cell_position;
        req_in.sym             = i_cell_symbol;
    end

    assign o_busy      = (r_count == tmse_pkg::Q_CW'(tmse_pkg::Q_DEPTH));
    assign push        = i_start && !o_busy;
    assign o_req_valid = (r_count != '0);
    assign pop         = i_req_pop && o_req_valid;
    assign o_req       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= req_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count != '0)
        else $error("queue empty after request push");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tmse_pkg::Q_CW'(tmse_pkg::Q_DEPTH))
        else $error("queue count overflow");

endmodule

// ===== sv/tmse_back.sv =====
module tmse_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [tmse_pkg::STATE_W-1:0]   i_accept_state,
    input  logic                           i_req_valid,
    input  tmse_pkg::t_req                 i_req,
    output logic                           o_req_pop,
    output logic                           o_valid,
    output logic [2:0]                     o_status,
    output logic [tmse_pkg::STATE_W-1:0]   o_current_state,
    output logic [tmse_pkg::POS_W-1:0]     o_head_position,
    output logic [tmse_pkg::SYM_W-1:0]     o_read_symbol
);

    tmse_pkg::t_bstate             r_bstate;
    tmse_pkg::t_bstate             n_bstate;
    logic [tmse_pkg::STATE_W-1:0]  r_state;
    logic [tmse_pkg::STATE_W-1:0]  n_state;
    logic [tmse_pkg::POS_W-1:0]    r_head;
    logic [tmse_pkg::POS_W-1:0]    n_head;
    logic [tmse_pkg::SYM_W-1:0]    r_sym;
    logic [tmse_pkg::SYM_W-1:0]    n_sym;
    logic                          r_is_read;
    logic                          n_is_read;

    logic                          r_o_valid;
    logic                          n_o_valid;
    tmse_pkg::t_status             r_o_status;
    tmse_pkg::t_status             n_o_status;
    logic [tmse_pkg::SYM_W-1:0]    r_o_sym;
    logic [tmse_pkg::SYM_W-1:0]    n_o_sym;
    logic [tmse_pkg::STATE_W-1:0]  r_o_state;
    logic [tmse_pkg::POS_W-1:0]    r_o_head;

    logic                          tape_we;
    logic [tmse_pkg::POS_W-1:0]    tape_waddr;
    logic [tmse_pkg::SYM_W-1:0]    tape_wdata;
    logic [tmse_pkg::POS_W-1:0]    tape_raddr;
    logic [tmse_pkg::SYM_W-1:0]    tape_rdata;
    logic                          rule_we;
    logic [tmse_pkg::RULE_AW-1:0]  rule_raddr;
    logic [tmse_pkg::RULE_W-1:0]   rule_rdata;
    tmse_pkg::t_rule               rule_q;

    assign rule_q = tmse_pkg::t_rule'(rule_rdata);

    tmse_ram #(
        .WIDTH(tmse_pkg::SYM_W),
        .DEPTH(tmse_pkg::TAPE_DEPTH)
    ) u_tape (
        .i_clk  (i_clk),
        .i_we   (tape_we),
        .i_waddr(tape_waddr),
        .i_wdata(tape_wdata),
        .i_raddr(tape_raddr),
        .o_rdata(tape_rdata)
    );

    tmse_ram #(
        .WIDTH(tmse_pkg::RULE_W),
        .DEPTH(tmse_pkg::RULE_DEPTH)
    ) u_rules (
        .i_clk  (i_clk),
        .i_we   (rule_we),
        .i_waddr(i_req.rule_addr),
        .i_wdata(i_req.rule),
        .i_raddr(rule_raddr),
        .o_rdata(rule_rdata)
    );

    always_comb begin
        n_bstate = r_bstate;
        case (r_bstate)
            tmse_pkg::BS_IDLE: begin
                if (i_req_valid &&
                    (i_req.op == tmse_pkg::OP_READ || i_req.op == tmse_pkg::OP_STEP)) begin
                    n_bstate = tmse_pkg::BS_TAPE;
                end
            end
            tmse_pkg::BS_TAPE: begin
                if (!r_is_read && r_state != i_accept_state) begin
                    n_bstate = tmse_pkg::BS_RULE;
                end else begin
                    n_bstate = tmse_pkg::BS_IDLE;
                end
            end
            tmse_pkg::BS_RULE: n_bstate = tmse_pkg::BS_IDLE;
            default:           n_bstate = tmse_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        o_req_pop  = 1'b0;
        tape_we    = 1'b0;
        tape_waddr = i_req.pos;
        tape_wdata = i_req.sym;
        tape_raddr = i_req.pos;
        rule_we    = 1'b0;
        rule_raddr = {r_state, tape_rdata};
        n_state    = r_state;
        n_head     = r_head;
        n_sym      = r_sym;
        n_is_read  = r_is_read;
        n_o_valid  = 1'b0;
        n_o_status = tmse_pkg::ST_DONE;
        n_o_sym    = '0;
        case (r_bstate)
            tmse_pkg::BS_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop = 1'b1;
                    case (i_req.op)
                        tmse_pkg::OP_LOAD: begin
                            rule_we   = 1'b1;
                            n_o_valid = 1'b1;
                        end
                        tmse_pkg::OP_WRITE: begin
                            tape_we   = 1'b1;
                            n_o_valid = 1'b1;
                        end
                        tmse_pkg::OP_READ: begin
                            n_is_read = 1'b1;
                        end
                        tmse_pkg::OP_RESTART: begin
                            n_state   = '0;
                            n_head    = '0;
                            n_o_valid = 1'b1;
                        end
                        tmse_pkg::OP_STEP: begin
                            tape_raddr = r_head;
                            n_is_read  = 1'b0;
                        end
                        default: begin
                            n_o_valid = 1'b1;
                        end
                    endcase
                end
            end
            tmse_pkg::BS_TAPE: begin
                n_sym   = tape_rdata;
                n_o_sym = tape_rdata;
                if (r_is_read) begin
                    n_o_valid = 1'b1;
                end else if (r_state == i_accept_state) begin
                    n_o_valid  = 1'b1;
                    n_o_status = tmse_pkg::ST_ACCEPTED;
                end
            end
            tmse_pkg::BS_RULE: begin
                n_o_valid = 1'b1;
                n_o_sym   = r_sym;
                if (!rule_q.defined) begin
                    n_o_status = tmse_pkg::ST_NO_RULE;
                end else begin
                    tape_we    = 1'b1;
                    tape_waddr = r_head;
                    tape_wdata = rule_q.write_sym;
                    n_state    = rule_q.next_state;
                    n_o_status = tmse_pkg::ST_STEPPED;
                    if (rule_q.move_right) begin
                        if (r_head == tmse_pkg::TAPE_LAST) begin
                            n_o_status = tmse_pkg::ST_OFF_TAPE;
                        end else begin
                            n_head = r_head + 1'b1;
                        end
                    end else begin
                        if (r_head == '0) begin
                            n_o_status = tmse_pkg::ST_OFF_TAPE;
                        end else begin
                            n_head = r_head - 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_o_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate  <= tmse_pkg::BS_IDLE;
            r_state   <= '0;
            r_head    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_bstate  <= n_bstate;
            r_state   <= n_state;
            r_head    <= n_head;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym      <= n_sym;
        r_is_read  <= n_is_read;
        r_o_status <= n_o_status;
        r_o_sym    <= n_o_sym;
        r_o_state  <= n_state;
        r_o_head   <= n_head;
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_current_state = r_o_state;
    assign o_head_position = r_o_head;
    assign o_read_symbol   = r_o_sym;

    a_rule_after_tape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bstate == tmse_pkg::BS_RULE |-> $past(r_bstate) == tmse_pkg::BS_TAPE)
        else $error("rule lookup without tape read");

    a_rule_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bstate == tmse_pkg::BS_RULE |=> r_bstate == tmse_pkg::BS_IDLE && o_valid)
        else $error("step did not complete after rule lookup");

    a_one_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(tape_we && rule_we))
        else $error("tape and rule table written together");

endmodule

// ===== sv/turing_machine_step_engine.sv =====
// channel   signals                                         direction
// request   start, busy, i_kind .. i_cell_symbol            in  (taken on start && !busy)
// result    o_valid, o_status, o_current_state,             out (one cycle strobe)
//           o_head_position, o_read_symbol
// config    psel, penable, pwrite, paddr, pwdata,           APB, accept_state at 0x0
//           prdata, pready
//
// Requests go into a two-entry queue; busy is high while it is full.
// Step: the executor does tape read, rule read, write back; it stops after the
// tape read when the state is accepting, as tape and rule memories have registered
// read ports. Read cell: tape read. Other requests: in idle. The result is registered.
// Synchronous active-low reset clears state, head, queue; accept_state -> 63.
// Tape and rule memories are not cleared. The receiver cannot stall.
module turing_machine_step_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [1:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           start,
    output logic                           busy,
    input  logic [tmse_pkg::KIND_W-1:0]    i_kind,
    input  logic [tmse_pkg::STATE_W-1:0]   i_rule_state,
    input  logic [tmse_pkg::SYM_W-1:0]     i_rule_symbol,
    input  logic [tmse_pkg::STATE_W-1:0]   i_rule_next_state,
    input  logic [tmse_pkg::SYM_W-1:0]     i_rule_write_symbol,
    input  logic                           i_rule_move_right,
    input  logic                           i_rule_defined,
    input  logic [tmse_pkg::POS_W-1:0]     i_cell_position,
    input  logic [tmse_pkg::SYM_W-1:0]     i_cell_symbol,
    output logic                           o_valid,
    output logic [2:0]                     o_status,
    output logic [tmse_pkg::STATE_W-1:0]   o_current_state,
    output logic [tmse_pkg::POS_W-1:0]     o_head_position,
    output logic [tmse_pkg::SYM_W-1:0]     o_read_symbol
);

    logic [tmse_pkg::STATE_W-1:0] r_accept_state;
    logic                         req_valid;
    logic                         req_pop;
    tmse_pkg::t_req               req;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_state <= tmse_pkg::ACCEPT_RESET;
        end else if (psel && penable && pwrite && paddr == tmse_pkg::REG_ACCEPT) begin
            r_accept_state <= pwdata[tmse_pkg::STATE_W-1:0];
        end
    end

    assign prdata = (paddr == tmse_pkg::REG_ACCEPT) ? 32'(r_accept_state) : 32'd0;

    tmse_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_kind             (i_kind),
        .i_rule_state       (i_rule_state),
        .i_rule_symbol      (i_rule_symbol),
        .i_rule_next_state  (i_rule_next_state),
        .i_rule_write_symbol(i_rule_write_symbol),
        .i_rule_move_right  (i_rule_move_right),
        .i_rule_defined     (i_rule_defined),
        .i_cell_position    (i_cell_position),
        .i_cell_symbol      (i_cell_symbol),
        .o_busy             (busy),
        .o_req_valid        (req_valid),
        .o_req              (req),
        .i_req_pop          (req_pop)
    );

    tmse_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept_state (r_accept_state),
        .i_req_valid    (req_valid),
        .i_req          (req),
        .o_req_pop      (req_pop),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_current_state(o_current_state),
        .o_head_position(o_head_position),
        .o_read_symbol  (o_read_symbol)
    );

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import tmse_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [STATE_W-1:0] rule_state;
        logic [SYM_W-1:0]   rule_symbol;
        t_rule              rule;
        logic [POS_W-1:0]   pos;
        logic [SYM_W-1:0]   cell_sym;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [STATE_W-1:0] mstate;
        logic [POS_W-1:0]   head;
        logic [SYM_W-1:0]   sym;
    } t_report;

    typedef struct packed {
        t_cmd    cmd;
        logic    typed;
        t_report want;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [1:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 start;
    logic                 busy;
    logic [KIND_W-1:0]    i_kind;
    logic [STATE_W-1:0]   i_rule_state;
    logic [SYM_W-1:0]     i_rule_symbol;
    logic [STATE_W-1:0]   i_rule_next_state;
    logic [SYM_W-1:0]     i_rule_write_symbol;
    logic                 i_rule_move_right;
    logic                 i_rule_defined;
    logic [POS_W-1:0]     i_cell_position;
    logic [SYM_W-1:0]     i_cell_symbol;
    logic                 o_valid;
    logic [2:0]           o_status;
    logic [STATE_W-1:0]   o_current_state;
    logic [POS_W-1:0]     o_head_position;
    logic [SYM_W-1:0]     o_read_symbol;

    // machine copy
    logic [SYM_W-1:0]     tape_mem [TAPE_DEPTH];
    t_rule                rule_mem [RULE_DEPTH];
    bit                   tape_known [TAPE_DEPTH];
    bit                   rule_known [RULE_DEPTH];
    logic [STATE_W-1:0]   cur_state  = '0;
    logic [POS_W-1:0]     head_pos   = '0;
    logic [STATE_W-1:0]   accept_reg = ACCEPT_RESET;

    t_report              due_reports [$];
    t_row                 dir_rows [$];
    int                   fails      = 0;
    int                   idle_pct   = 0;

    turing_machine_step_engine DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .start               (start),
        .busy                (busy),
        .i_kind              (i_kind),
        .i_rule_state        (i_rule_state),
        .i_rule_symbol       (i_rule_symbol),
        .i_rule_next_state   (i_rule_next_state),
        .i_rule_write_symbol (i_rule_write_symbol),
        .i_rule_move_right   (i_rule_move_right),
        .i_rule_defined      (i_rule_defined),
        .i_cell_position     (i_cell_position),
        .i_cell_symbol       (i_cell_symbol),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_current_state     (o_current_state),
        .o_head_position     (o_head_position),
        .o_read_symbol       (o_read_symbol)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic t_cmd cmd_of(input logic [KIND_W-1:0] k);
        t_cmd c;
        c = '0;
        c.kind = k;
        return c;
    endfunction

    function automatic t_cmd rule_cmd(input logic [STATE_W-1:0] st, input logic [SYM_W-1:0] sy,
                                      input logic [STATE_W-1:0] nx, input logic [SYM_W-1:0] ws,
                                      input logic right, input logic def);
        t_cmd c;
        c = cmd_of(KIND_LOAD);
        c.rule_state = st;
        c.rule_symbol = sy;
        c.rule = '{defined: def, move_right: right, write_sym: ws, next_state: nx};
        return c;
    endfunction

    function automatic t_cmd cell_cmd(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                                      input logic [SYM_W-1:0] sy);
        t_cmd c;
        c = cmd_of(k);
        c.pos = p;
        c.cell_sym = sy;
        return c;
    endfunction

    function automatic t_report rep(input t_status s, input logic [STATE_W-1:0] st,
                                    input logic [POS_W-1:0] hd, input logic [SYM_W-1:0] sy);
        t_report r;
        r.status = s;
        r.mstate = st;
        r.head = hd;
        r.sym = sy;
        return r;
    endfunction

    function automatic t_row row(input t_cmd c, input logic typed, input t_report w);
        t_row r;
        r.cmd = c;
        r.typed = typed;
        r.want = w;
        return r;
    endfunction

    function automatic void add_row(input t_row r);
        dir_rows = {dir_rows, r};
    endfunction

    // most rules defined; some jump straight to the accepting state
    function automatic t_rule rand_rule();
        t_rule r;
        r.defined = ($urandom_range(99) < 85);
        r.move_right = 1'($urandom_range(1));
        r.write_sym = SYM_W'($urandom_range(SYMBOL_COUNT - 1));
        r.next_state = ($urandom_range(9) == 0) ? accept_reg :
                       STATE_W'($urandom_range(STATE_COUNT - 1));
        return r;
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd             c;
        int               pick;
        logic [SYM_W-1:0] under;
        c = '0;
        c.rule = rand_rule();
        c.rule_state = STATE_W'($urandom_range(STATE_COUNT - 1));
        c.rule_symbol = SYM_W'($urandom_range(SYMBOL_COUNT - 1));
        c.pos = POS_W'($urandom_range(TAPE_DEPTH - 1));
        c.cell_sym = SYM_W'($urandom_range(SYMBOL_COUNT - 1));
        pick = $urandom_range(99);
        if (pick < 55)      c.kind = KIND_STEP;
        else if (pick < 67) c.kind = KIND_LOAD;
        else if (pick < 77) c.kind = KIND_WRITE;
        else if (pick < 85) c.kind = KIND_READ;
        else if (pick < 95) c.kind = KIND_RESTART;
        else                c.kind = KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
        // an entry is written before anything reads it
        if (c.kind == KIND_READ && !tape_known[c.pos]) begin
            c.kind = KIND_WRITE;
        end else if (c.kind == KIND_STEP) begin
            under = tape_mem[head_pos];
            if (!tape_known[head_pos]) begin
                c.kind = KIND_WRITE;
                c.pos  = head_pos;
            end else if (cur_state != accept_reg && !rule_known[{cur_state, under}]) begin
                c.kind        = KIND_LOAD;
                c.rule_state  = cur_state;
                c.rule_symbol = under;
            end
        end
        return c;
    endfunction

    function automatic t_report run_request(input t_cmd c);
        t_report          r;
        t_rule            ent;
        logic [SYM_W-1:0] sym;
        r = '0;
        r.status = ST_DONE;
        case (c.kind)
            KIND_LOAD: begin
                rule_mem[{c.rule_state, c.rule_symbol}] = c.rule;
                rule_known[{c.rule_state, c.rule_symbol}] = 1'b1;
            end
            KIND_WRITE: begin
                tape_mem[c.pos] = c.cell_sym;
                tape_known[c.pos] = 1'b1;
            end
            KIND_READ: begin
                r.sym = tape_mem[c.pos];
            end
            KIND_RESTART: begin
                cur_state = '0;
                head_pos = '0;
            end
            KIND_STEP: begin
                sym = tape_mem[head_pos];
                r.sym = sym;
                if (cur_state == accept_reg) begin
                    r.status = ST_ACCEPTED;
                end else begin
                    ent = rule_mem[{cur_state, sym}];
                    if (!ent.defined) begin
                        r.status = ST_NO_RULE;
                    end else begin
                        tape_mem[head_pos] = ent.write_sym;
                        cur_state = ent.next_state;
                        r.status = ST_STEPPED;
                        if (ent.move_right) begin
                            if (head_pos == TAPE_LAST) r.status = ST_OFF_TAPE;
                            else head_pos = head_pos + 1'b1;
                        end else begin
                            if (head_pos == '0) r.status = ST_OFF_TAPE;
                            else head_pos = head_pos - 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        r.mstate = cur_state;
        r.head = head_pos;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (due_reports.size() == 0) begin
                $display("%0t: unexpected result: status %0d state %0d head %0d sym %0d",
                         $time, o_status, o_current_state, o_head_position, o_read_symbol);
                fails++;
            end else begin
                want = due_reports.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("current_state", 32'(want.mstate), 32'(o_current_state));
                check_field("head_position", 32'(want.head), 32'(o_head_position));
                check_field("read_symbol", 32'(want.sym), 32'(o_read_symbol));
            end
        end
    end

    // called at a falling edge; returns at a falling edge
    task automatic pause_sender();
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic send(input t_cmd c, input logic typed, input t_report want);
        t_report predicted;
        pause_sender();
        start               <= 1'b1;
        i_kind              <= c.kind;
        i_rule_state        <= c.rule_state;
        i_rule_symbol       <= c.rule_symbol;
        i_rule_next_state   <= c.rule.next_state;
        i_rule_write_symbol <= c.rule.write_sym;
        i_rule_move_right   <= c.rule.move_right;
        i_rule_defined      <= c.rule.defined;
        i_cell_position     <= c.pos;
        i_cell_symbol       <= c.cell_sym;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = run_request(c);
        if (typed) predicted = want;
        due_reports = {due_reports, predicted};
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (due_reports.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_ACCEPT;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_accept();
        logic [31:0] rd;
        apb_xfer(1'b0, '0, rd);
        check_field("accept_state readback", 32'(accept_reg), rd);
    endtask

    task automatic set_accept(input logic [STATE_W-1:0] v);
        logic [31:0] rd;
        apb_xfer(1'b1, 32'(v), rd);
        accept_reg = v;
        check_accept();
    endtask

    task automatic run_random(input int count);
        repeat (count) begin
            send(rand_cmd(), 1'b0, '0);
            if ($urandom_range(149) == 0) wait_idle();
        end
    endtask

    initial begin
        int   n;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        start               = 1'b0;
        i_kind              = '0;
        i_rule_state        = '0;
        i_rule_symbol       = '0;
        i_rule_next_state   = '0;
        i_rule_write_symbol = '0;
        i_rule_move_right   = 1'b0;
        i_rule_defined      = 1'b0;
        i_cell_position     = '0;
        i_cell_symbol       = '0;
        idle_pct            = 36;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        check_accept();

        // directed: extremes, every kind, accept / no rule / off tape
        add_row(row(cmd_of(KIND_RESTART), 1'b1, rep(ST_DONE, '0, '0, '0)));
        add_row(row(cell_cmd(KIND_WRITE, '0, 4'd15), 1'b1, rep(ST_DONE, '0, '0, '0)));
        add_row(row(cell_cmd(KIND_WRITE, TAPE_LAST, 4'd0), 1'b1, rep(ST_DONE, '0, '0, '0)));
        add_row(row(cell_cmd(KIND_WRITE, 10'd1, 4'd0), 1'b1, rep(ST_DONE, '0, '0, '0)));
        add_row(row(cell_cmd(KIND_READ, '0, 4'd0), 1'b1, rep(ST_DONE, '0, '0, 4'd15)));
        add_row(row(cell_cmd(KIND_READ, TAPE_LAST, 4'd15), 1'b1, rep(ST_DONE, '0, '0, '0)));
        add_row(row(rule_cmd(6'd0, 4'd15, 6'd63, 4'd10, 1'b1, 1'b1), 1'b1,
                    rep(ST_DONE, '0, '0, '0)));
        add_row(row(rule_cmd(6'd63, 4'd0, 6'd0, 4'd0, 1'b0, 1'b0), 1'b1,
                    rep(ST_DONE, '0, '0, '0)));
        add_row(row(rule_cmd(6'd0, 4'd10, 6'd1, 4'd3, 1'b0, 1'b1), 1'b1,
                    rep(ST_DONE, '0, '0, '0)));
        add_row(row(rule_cmd(6'd1, 4'd3, 6'd0, 4'd15, 1'b1, 1'b0), 1'b1,
                    rep(ST_DONE, '0, '0, '0)));
        add_row(row(cmd_of(KIND_STEP), 1'b0, '0));
        add_row(row(cmd_of(KIND_STEP), 1'b0, '0));
        add_row(row(cmd_of(KIND_SPARE_LAST), 1'b0, '0));
        add_row(row(cmd_of(KIND_RESTART), 1'b1, rep(ST_DONE, '0, '0, '0)));
        add_row(row(cmd_of(KIND_STEP), 1'b0, '0));
        add_row(row(cmd_of(KIND_STEP), 1'b0, '0));
        add_row(row(rule_cmd(6'd63, 4'd15, 6'd63, 4'd15, 1'b1, 1'b1), 1'b0, '0));
        foreach (dir_rows[i]) send(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

        wait_idle();
        set_accept('0);
        run_random(700);

        idle_pct = 56;
        wait_idle();
        set_accept(STATE_W'($urandom_range(STATE_COUNT - 2, 1)));
        run_random(700);

        idle_pct = 0;
        wait_idle();
        set_accept(ACCEPT_RESET);
        run_random(600);

        start <= 1'b0;
        n = 0;
        while (due_reports.size() != 0 && n < 1000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (10) @(negedge i_clk);
        if (due_reports.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, due_reports.size());
            fails++;
        end
        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
